// ===== rtl/ppcb_pkg.sv =====
package ppcb_pkg;

  // Default values of the top-level parameters.
  localparam int NUM_PEERS_DEF = 64;
  localparam int TIME_BITS_DEF = 48;
  localparam int RUN_BITS_DEF  = 16;

  // Fixed port field widths.
  localparam int REQ_W     = 3;
  localparam int PEER_W    = 6;
  localparam int NOW_W     = 48;
  localparam int MODE_W    = 2;
  localparam int EVENT_W   = 3;
  localparam int LIMIT_W   = 16;
  localparam int TIMEOUT_W = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIMEOUT  = 2'd2;

  localparam logic [LIMIT_W-1:0]   FAILURE_LIMIT_RST = 16'd5;
  localparam logic [LIMIT_W-1:0]   SUCCESS_LIMIT_RST = 16'd3;
  localparam logic [TIMEOUT_W-1:0] OPEN_TIMEOUT_RST  = 32'd30000;

  // Request types. Codes above REQ_QUERY are undefined.
  localparam logic [REQ_W-1:0] REQ_ACQUIRE    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SUCCESS    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FAILURE    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FORCE_OPEN = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESET      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd5;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE      = 3'd0,
    EV_OPENED    = 3'd1,
    EV_HALF      = 3'd2,
    EV_CLOSED    = 3'd3,
    EV_FAST_FAIL = 3'd4,
    EV_UNKNOWN   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

endpackage

// ===== rtl/ppcb_if.sv =====
interface ppcb_in_if;
  import ppcb_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [PEER_W-1:0]   peer_index;
  logic [NOW_W-1:0]    now_ms;

  modport source (output valid, output req_type, output peer_index, output now_ms,
                  input ready);
  modport sink   (input valid, input req_type, input peer_index, input now_ms,
                  output ready);
endinterface

interface ppcb_out_if;
  import ppcb_pkg::*;

  logic                valid;
  logic                ready;
  logic                allowed;
  logic [MODE_W-1:0]   breaker_state;
  logic [EVENT_W-1:0]  event_code;

  modport source (output valid, output allowed, output breaker_state, output event_code,
                  input ready);
  modport sink   (input valid, input allowed, input breaker_state, input event_code,
                  output ready);
endinterface

// ===== rtl/per_peer_circuit_breaker.sv =====
// Channel  Role    Payload                                        Transfer
// in_ch    sink    req_type[2:0], peer_index[5:0], now_ms[47:0]   valid & ready
// out_ch   source  allowed, breaker_state[1:0], event_code[2:0]   valid & ready
// cfg_*    write   cfg_index[1:0], cfg_wdata[31:0]                cfg_we
//
// For each event, the transfer cycle launches the registered table read, and
// the execute cycle updates the entry and loads the output register.
// After reset a clearing pass zeroes the table; in_ch.ready
// stays low until it ends. Configuration writes are taken at any time.
// A result waiting on out_ch holds back only the execute cycle of the next
// event, so a new event can be accepted while the previous result is pending.
module per_peer_circuit_breaker #(
  parameter int NUM_PEERS = ppcb_pkg::NUM_PEERS_DEF,
  parameter int TIME_BITS = ppcb_pkg::TIME_BITS_DEF,
  parameter int RUN_BITS  = ppcb_pkg::RUN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ppcb_in_if.sink                           in_ch,
  ppcb_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ppcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppcb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ppcb_pkg::*;

  // Command and status between the sequencer and the table datapath.
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  // The sequencer runs the clearing pass, accepts one event at a time and
  // commits its result only when the output register is free or being drained.
  ppcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the breaker table, the configuration registers and the
  // output register; it decides each event in the execute cycle.
  ppcb_datapath #(
    .NUM_PEERS (NUM_PEERS),
    .TIME_BITS (TIME_BITS),
    .RUN_BITS  (RUN_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_req_type       (in_ch.req_type),
    .in_peer_index     (in_ch.peer_index),
    .in_now_ms         (in_ch.now_ms),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_allowed       (out_ch.allowed),
    .out_breaker_state (out_ch.breaker_state),
    .out_event_code    (out_ch.event_code)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

// ===== rtl/ppcb_ctrl.sv =====
module ppcb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ppcb_pkg::dp_cmd_t      cmd,
  input  ppcb_pkg::dp_status_t   status
);
  import ppcb_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC:  cmd.commit = slot_free;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EXEC))
    else $error("accepted event did not move to execute");

  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result committed over an untaken result");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !cmd.capture && !cmd.commit)
    else $error("event handled during clearing pass");
`endif

endmodule

// ===== rtl/ppcb_datapath.sv =====
module ppcb_datapath #(
  parameter int NUM_PEERS = ppcb_pkg::NUM_PEERS_DEF,
  parameter int TIME_BITS = ppcb_pkg::TIME_BITS_DEF,
  parameter int RUN_BITS  = ppcb_pkg::RUN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ppcb_pkg::dp_cmd_t                 cmd,
  output ppcb_pkg::dp_status_t              status,
  input  logic [ppcb_pkg::REQ_W-1:0]        in_req_type,
  input  logic [ppcb_pkg::PEER_W-1:0]       in_peer_index,
  input  logic [ppcb_pkg::NOW_W-1:0]        in_now_ms,
  input  logic                              cfg_we,
  input  logic [ppcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppcb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              out_allowed,
  output logic [ppcb_pkg::MODE_W-1:0]       out_breaker_state,
  output logic [ppcb_pkg::EVENT_W-1:0]      out_event_code
);
  import ppcb_pkg::*;

  localparam int PEER_BITS = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam int CMP_BITS  = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;
  localparam int LIM_BITS  = (RUN_BITS > LIMIT_W) ? RUN_BITS : LIMIT_W;

  typedef struct packed {
    logic                 valid;
    mode_t                mode;
    logic [TIME_BITS-1:0] opened;
    logic [RUN_BITS-1:0]  fail_run;
    logic [RUN_BITS-1:0]  succ_run;
  } entry_t;

  entry_t mem [NUM_PEERS];

  // Configuration registers.
  logic [LIMIT_W-1:0]   fail_limit_r;
  logic [LIMIT_W-1:0]   succ_limit_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  // Captured event.
  logic [REQ_W-1:0]     type_r;
  logic [TIME_BITS-1:0] now_r;
  logic [PEER_BITS-1:0] addr_r;
  logic                 oob_r;
  entry_t               rd_r;

  logic [PEER_BITS-1:0] clr_addr_r;

  logic                 out_allowed_r;
  mode_t                out_state_r;
  event_t               out_event_r;

  logic [31:0]          idx32;
  logic [63:0]          now64;

  entry_t               cur;
  entry_t               nxt_e;
  logic                 wr_en;
  logic                 allowed;
  mode_t                state;
  event_t               ev;
  logic [TIME_BITS-1:0] elapsed;
  logic                 expired;
  logic [RUN_BITS-1:0]  fail_inc;
  logic [RUN_BITS-1:0]  succ_inc;

  assign idx32 = 32'(in_peer_index);
  assign now64 = 64'(in_now_ms);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_limit_r <= FAILURE_LIMIT_RST;
      succ_limit_r <= SUCCESS_LIMIT_RST;
      timeout_r    <= OPEN_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAILURE_LIMIT: fail_limit_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_SUCCESS_LIMIT: succ_limit_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_OPEN_TIMEOUT:  timeout_r    <= cfg_wdata[TIMEOUT_W-1:0];
        default:           timeout_r    <= timeout_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign status.clr_last = (clr_addr_r == PEER_BITS'(NUM_PEERS - 1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r <= in_req_type;
      now_r  <= now64[TIME_BITS-1:0];
      addr_r <= idx32[PEER_BITS-1:0];
      oob_r  <= (idx32 >= 32'(NUM_PEERS));
    end
  end

  // Table memory: one write port shared by the clearing pass and write-back,
  // one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.commit && wr_en) begin
      mem[addr_r] <= nxt_e;
    end
    if (cmd.capture) begin
      rd_r <= mem[idx32[PEER_BITS-1:0]];
    end
  end

  always_comb begin
    cur = rd_r;
    if (!rd_r.valid && (type_r == REQ_ACQUIRE || type_r == REQ_FAILURE)) begin
      cur       = '0;
      cur.valid = 1'b1;
    end
    elapsed  = now_r - cur.opened;
    expired  = (CMP_BITS'(elapsed) >= CMP_BITS'(timeout_r));
    fail_inc = (&cur.fail_run) ? cur.fail_run : cur.fail_run + 1'b1;
    succ_inc = (&cur.succ_run) ? cur.succ_run : cur.succ_run + 1'b1;

    nxt_e   = cur;
    wr_en   = 1'b0;
    allowed = 1'b0;
    state   = MODE_CLOSED;
    ev      = EV_UNKNOWN;

    if (!oob_r) begin
      if (type_r > REQ_QUERY) begin
        state = rd_r.valid ? rd_r.mode : MODE_CLOSED;
        ev    = EV_NONE;
      end else if (cur.valid) begin
        wr_en = 1'b1;
        ev    = EV_NONE;
        case (type_r)
          REQ_ACQUIRE: begin
            case (cur.mode)
              MODE_CLOSED: begin
                if (LIM_BITS'(cur.fail_run) >= LIM_BITS'(fail_limit_r)) begin
                  nxt_e.mode     = MODE_OPEN;
                  nxt_e.opened   = now_r;
                  nxt_e.succ_run = '0;
                  ev             = EV_OPENED;
                end else begin
                  allowed = 1'b1;
                end
              end
              MODE_OPEN: begin
                if (expired) begin
                  nxt_e.mode = MODE_HALF;
                  allowed    = 1'b1;
                  ev         = EV_HALF;
                end else begin
                  ev = EV_FAST_FAIL;
                end
              end
              default: allowed = 1'b1;
            endcase
          end
          REQ_SUCCESS: begin
            nxt_e.fail_run = '0;
            nxt_e.succ_run = succ_inc;
            if (cur.mode == MODE_HALF &&
                LIM_BITS'(succ_inc) >= LIM_BITS'(succ_limit_r)) begin
              nxt_e.mode = MODE_CLOSED;
              ev         = EV_CLOSED;
            end
          end
          REQ_FAILURE: begin
            nxt_e.fail_run = fail_inc;
            nxt_e.succ_run = '0;
            if ((cur.mode == MODE_CLOSED &&
                 LIM_BITS'(fail_inc) >= LIM_BITS'(fail_limit_r)) ||
                cur.mode == MODE_HALF) begin
              nxt_e.mode   = MODE_OPEN;
              nxt_e.opened = now_r;
              ev           = EV_OPENED;
            end
          end
          REQ_FORCE_OPEN: begin
            nxt_e.mode   = MODE_OPEN;
            nxt_e.opened = now_r;
            ev           = EV_OPENED;
          end
          REQ_RESET: begin
            nxt_e.mode     = MODE_CLOSED;
            nxt_e.fail_run = '0;
            nxt_e.succ_run = '0;
            ev             = EV_CLOSED;
          end
          REQ_QUERY: begin
            if (cur.mode == MODE_OPEN && expired) begin
              nxt_e.mode = MODE_HALF;
              ev         = EV_HALF;
            end
          end
          default: wr_en = 1'b0;
        endcase
        state = nxt_e.mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_allowed_r <= allowed;
      out_state_r   <= state;
      out_event_r   <= ev;
    end
  end

  assign out_allowed       = out_allowed_r;
  assign out_breaker_state = out_state_r;
  assign out_event_code    = out_event_r;

endmodule
